### hw/rtl/pwms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwms_pkg
// Shared constants, codes and types of the multichannel PWM with shadow
// update: channel count, counter width, control bit positions and the
// classified command that travels from the front end to the channel engine.
// ----------------------------------------------------------------------------
package pwms_pkg;

	// Sizing
	localparam int CHANNELS   = 6;
	localparam int COUNT_BITS = 32;
	localparam int CH_BITS    = 3;
	localparam int SEL_BITS   = 2;
	localparam int FUNC_BITS  = 2;
	localparam int DATA_BITS  = 32;
	localparam int REPORT_CH  = 6;
	localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Control word layout
	localparam int CTL_BITS      = 10;
	localparam int CTL_START_BIT = 0;
	localparam int CTL_UPD_BIT   = 2;
	localparam int CTL_LVL_BIT   = 8;

	// Function codes of an input transaction
	localparam logic [FUNC_BITS-1:0] FUNC_TICK  = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd2;

	// Register selector codes
	localparam logic [SEL_BITS-1:0] SEL_CTL    = 2'd0;
	localparam logic [SEL_BITS-1:0] SEL_PERIOD = 2'd1;
	localparam logic [SEL_BITS-1:0] SEL_DUTY   = 2'd2;

	// Command queue sizing
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	// Classified operation
	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_WR_CTL,
		OP_WR_PERIOD,
		OP_WR_DUTY,
		OP_RD_CTL,
		OP_RD_PERIOD,
		OP_RD_DUTY
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [CH_IDX_BITS-1:0] ch;
		logic [DATA_BITS-1:0]   data;
	} cmd_t;

endpackage

### hw/rtl/pwms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwms_front
// Front end: takes input transactions and classifies them into commands,
// resolving out-of-range channels and selectors to no-ops and masking
// period and duty values to the counter width.
// ----------------------------------------------------------------------------
module pwms_front (
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [pwms_pkg::FUNC_BITS-1:0] func,
	input  logic [pwms_pkg::CH_BITS-1:0]   channel,
	input  logic [pwms_pkg::SEL_BITS-1:0]  reg_sel,
	input  logic [pwms_pkg::DATA_BITS-1:0] write_data,
	input  logic                           q_full,
	output logic                           q_push,
	output pwms_pkg::cmd_t                 q_cmd
);

	logic ch_ok;

	// Handshake: stall while the queue is full
	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;
	assign ch_ok      = ({1'b0, channel} < (pwms_pkg::CH_BITS + 1)'(pwms_pkg::CHANNELS));

	// Classify
	always_comb begin
		q_cmd      = '0;
		q_cmd.op   = pwms_pkg::OP_NOP;
		q_cmd.ch   = pwms_pkg::CH_IDX_BITS'(channel);
		q_cmd.data = write_data;
		case (func)
			pwms_pkg::FUNC_TICK: begin
				q_cmd.op = pwms_pkg::OP_TICK;
			end
			pwms_pkg::FUNC_WRITE: begin
				if (ch_ok) begin
					case (reg_sel)
						pwms_pkg::SEL_CTL: begin
							q_cmd.op = pwms_pkg::OP_WR_CTL;
						end
						pwms_pkg::SEL_PERIOD: begin
							q_cmd.op   = pwms_pkg::OP_WR_PERIOD;
							q_cmd.data = pwms_pkg::DATA_BITS'(
								write_data[pwms_pkg::COUNT_BITS-1:0]);
						end
						pwms_pkg::SEL_DUTY: begin
							q_cmd.op   = pwms_pkg::OP_WR_DUTY;
							q_cmd.data = pwms_pkg::DATA_BITS'(
								write_data[pwms_pkg::COUNT_BITS-1:0]);
						end
						default: begin
							q_cmd.op = pwms_pkg::OP_NOP;
						end
					endcase
				end
			end
			pwms_pkg::FUNC_READ: begin
				if (ch_ok) begin
					case (reg_sel)
						pwms_pkg::SEL_CTL:    q_cmd.op = pwms_pkg::OP_RD_CTL;
						pwms_pkg::SEL_PERIOD: q_cmd.op = pwms_pkg::OP_RD_PERIOD;
						pwms_pkg::SEL_DUTY:   q_cmd.op = pwms_pkg::OP_RD_DUTY;
						default:              q_cmd.op = pwms_pkg::OP_NOP;
					endcase
				end
			end
			default: begin
				q_cmd.op = pwms_pkg::OP_NOP;
			end
		endcase
	end

endmodule

### hw/rtl/pwms_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwms_queue
// Short command queue between the front end and the channel engine, so that
// each side can stall on its own. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module pwms_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pwms_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output pwms_pkg::cmd_t head_cmd
);

	pwms_pkg::cmd_t                   entry_q [pwms_pkg::Q_DEPTH];
	logic [pwms_pkg::Q_PTR_BITS-1:0]  wr_ptr_q;
	logic [pwms_pkg::Q_PTR_BITS-1:0]  rd_ptr_q;
	logic [pwms_pkg::Q_CNT_BITS-1:0]  count_q;
	logic                             do_pop;

	assign full      = (count_q == pwms_pkg::Q_CNT_BITS'(pwms_pkg::Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = entry_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

### hw/rtl/pwms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwms_back
// Channel engine: executes one command per unstalled cycle on the per-channel
// lanes (control, shadow and active period and duty, counter, pending update,
// started flag), then samples the output levels into the result register.
// ----------------------------------------------------------------------------
module pwms_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  pwms_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [pwms_pkg::DATA_BITS-1:0]  read_data,
	output logic [pwms_pkg::REPORT_CH-1:0]  pwm_level,
	output logic [pwms_pkg::REPORT_CH-1:0]  started_mask
);

	localparam int CB = pwms_pkg::COUNT_BITS;
	localparam int NC = pwms_pkg::CHANNELS;

	// Per-channel lanes
	logic [pwms_pkg::CTL_BITS-1:0] ctl_q      [NC];
	logic [CB-1:0]                 sh_per_q   [NC];
	logic [CB-1:0]                 sh_duty_q  [NC];
	logic [CB-1:0]                 act_per_q  [NC];
	logic [CB-1:0]                 act_duty_q [NC];
	logic [CB-1:0]                 count_q    [NC];
	logic [NC-1:0]                 pend_q;
	logic [NC-1:0]                 started_q;

	// Execute result and output register
	logic                           valid_s1;
	logic [pwms_pkg::DATA_BITS-1:0] rd_s1;
	logic                           out_valid_q;
	logic [pwms_pkg::DATA_BITS-1:0] out_rd_q;
	logic [pwms_pkg::REPORT_CH-1:0] out_lvl_q;
	logic [pwms_pkg::REPORT_CH-1:0] out_started_q;

	logic                           adv;
	logic                           fire;
	logic [pwms_pkg::DATA_BITS-1:0] rd_val;
	logic [pwms_pkg::REPORT_CH-1:0] lvl_now;
	logic [pwms_pkg::REPORT_CH-1:0] started_now;

	assign adv     = !out_valid_q || !result_stall;
	assign fire    = cmd_valid && (!valid_s1 || adv);
	assign cmd_pop = fire;

	// Read data mux
	always_comb begin
		case (cmd.op)
			pwms_pkg::OP_RD_CTL:
				rd_val = pwms_pkg::DATA_BITS'(ctl_q[cmd.ch]);
			pwms_pkg::OP_RD_PERIOD:
				rd_val = pwms_pkg::DATA_BITS'(sh_per_q[cmd.ch]);
			pwms_pkg::OP_RD_DUTY:
				rd_val = pwms_pkg::DATA_BITS'(sh_duty_q[cmd.ch]);
			default:
				rd_val = '0;
		endcase
	end

	// Channel lanes: tick and register writes
	for (genvar c = 0; c < NC; c++) begin : g_lane
		logic [CB:0]                   next_cnt;
		logic                          wrap;
		logic                          hit;
		logic [pwms_pkg::CTL_BITS-1:0] nw;
		logic                          arm;
		logic                          go;

		assign next_cnt = {1'b0, count_q[c]} + 1'b1;
		assign wrap     = (next_cnt >= {1'b0, act_per_q[c]});
		assign hit      = (cmd.ch == pwms_pkg::CH_IDX_BITS'(c));

		always_comb begin
			nw = cmd.data[pwms_pkg::CTL_BITS-1:0];
			if (started_q[c])
				nw[pwms_pkg::CTL_LVL_BIT] = ctl_q[c][pwms_pkg::CTL_LVL_BIT];
		end
		assign arm = !ctl_q[c][pwms_pkg::CTL_UPD_BIT] && nw[pwms_pkg::CTL_UPD_BIT];
		assign go  = nw[pwms_pkg::CTL_START_BIT] && !started_q[c];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_q[c]      <= '0;
				sh_per_q[c]   <= '0;
				sh_duty_q[c]  <= '0;
				act_per_q[c]  <= '0;
				act_duty_q[c] <= '0;
				count_q[c]    <= '0;
				pend_q[c]     <= 1'b0;
				started_q[c]  <= 1'b0;
			end else if (fire) begin
				case (cmd.op)
					pwms_pkg::OP_TICK: begin
						if (started_q[c]) begin
							if (wrap) begin
								count_q[c] <= '0;
								if (pend_q[c]) begin
									act_per_q[c]  <= sh_per_q[c];
									act_duty_q[c] <= sh_duty_q[c];
									pend_q[c]     <= 1'b0;
								end
							end else begin
								count_q[c] <= next_cnt[CB-1:0];
							end
						end
					end
					pwms_pkg::OP_WR_CTL: begin
						if (hit) begin
							ctl_q[c] <= nw & ~(pwms_pkg::CTL_BITS'(1)
								<< pwms_pkg::CTL_START_BIT);
							if (go) begin
								started_q[c] <= 1'b1;
								count_q[c]   <= '0;
								// Start is a period start: apply any update now
								if (pend_q[c] || arm) begin
									act_per_q[c]  <= sh_per_q[c];
									act_duty_q[c] <= sh_duty_q[c];
								end
								pend_q[c] <= 1'b0;
							end else if (arm) begin
								pend_q[c] <= 1'b1;
							end
						end
					end
					pwms_pkg::OP_WR_PERIOD: begin
						if (hit)
							sh_per_q[c] <= cmd.data[CB-1:0];
					end
					pwms_pkg::OP_WR_DUTY: begin
						if (hit)
							sh_duty_q[c] <= cmd.data[CB-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Output levels from the settled lane state
	always_comb begin
		lvl_now     = '0;
		started_now = '0;
		for (int c = 0; c < pwms_pkg::REPORT_CH; c++) begin
			if (c < NC) begin
				if (started_q[c]) begin
					started_now[c] = 1'b1;
					lvl_now[c] = (count_q[c] < act_duty_q[c])
						? ctl_q[c][pwms_pkg::CTL_LVL_BIT]
						: !ctl_q[c][pwms_pkg::CTL_LVL_BIT];
				end
			end
		end
	end

	// Execute stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!valid_s1 || adv)
				valid_s1 <= fire;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			rd_s1 <= rd_val;
		if (adv && valid_s1) begin
			out_rd_q      <= rd_s1;
			out_lvl_q     <= lvl_now;
			out_started_q <= started_now;
		end
	end

	assign result_valid = out_valid_q;
	assign read_data    = out_rd_q;
	assign pwm_level    = out_lvl_q;
	assign started_mask = out_started_q;

endmodule

### hw/rtl/multichannel_pwm_with_shadow_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pwm_with_shadow_update
// Six-channel PWM timer with shadowed period and first-phase length.
//
// Input channel (item_valid / item_stall): one transaction per operation,
// a clock tick, a register write or a register read. Output channel
// (result_valid / result_stall): one result per input transaction, in order,
// carrying read data, all channel levels and the started mask as they stand
// after that operation.
// Throughput is one transaction per cycle while the receiver does not stall;
// the channel engine then executes one command each cycle, with all channel
// counters updated in parallel. An accepted transaction is written into the
// command queue, executes in the channel engine and then reaches the output
// register. Reset clears the channel registers, counters and flags, the queue
// pointers and the valid bits; no channel runs until started. When the
// receiver stalls, the output register holds, the execute stage fills, then
// the two-entry queue fills and item_stall rises.
// ----------------------------------------------------------------------------
module multichannel_pwm_with_shadow_update (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [pwms_pkg::FUNC_BITS-1:0]  func,
	input  logic [pwms_pkg::CH_BITS-1:0]    channel,
	input  logic [pwms_pkg::SEL_BITS-1:0]   reg_sel,
	input  logic [pwms_pkg::DATA_BITS-1:0]  write_data,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [pwms_pkg::DATA_BITS-1:0]  read_data,
	output logic [pwms_pkg::REPORT_CH-1:0]  pwm_level,
	output logic [pwms_pkg::REPORT_CH-1:0]  started_mask
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_not_empty;
	pwms_pkg::cmd_t q_in_cmd;
	pwms_pkg::cmd_t q_head_cmd;

	// Front end: handshake and classification
	pwms_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.func       (func),
		.channel    (channel),
		.reg_sel    (reg_sel),
		.write_data (write_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_in_cmd)
	);

	// Command queue
	pwms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_cmd  (q_head_cmd)
	);

	// Channel engine
	pwms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (q_head_cmd),
		.cmd_pop      (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.pwm_level    (pwm_level),
		.started_mask (started_mask)
	);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the six-channel PWM timer with shadow update.
// A queue of operations (ticks, register writes and reads) feeds a driver on
// the input channel; a monitor keeps its own model of every channel, predicts
// the read data, levels and started mask of each transaction, and compares
// them with the results in order. Both sides idle at random in two of three
// phases; the receiver holds off once, long enough to back up the block.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CH_N = pwms_pkg::CHANNELS;
	localparam int TOTAL_RANDOM = 700;
	localparam int HOLDOFF_CYCLES = 40;
	localparam int DRAIN_CYCLES = 12;
	localparam int TIMEOUT_NS = 400000;
	localparam int MAX_SHOWN = 10;

	// Codes with no name in the package
	localparam logic [pwms_pkg::FUNC_BITS-1:0] FUNC_NOP = 2'd3;
	localparam logic [pwms_pkg::SEL_BITS-1:0] SEL_NONE = 2'd3;

	localparam logic [63:0] COUNT_MASK64 = (64'd1 << pwms_pkg::COUNT_BITS) - 64'd1;
	localparam logic [31:0] COUNT_MASK = COUNT_MASK64[31:0];

	typedef struct {
		logic [pwms_pkg::FUNC_BITS-1:0] func;
		logic [pwms_pkg::CH_BITS-1:0]   chan;
		logic [pwms_pkg::SEL_BITS-1:0]  sel;
		logic [pwms_pkg::DATA_BITS-1:0] data;
	} pwm_op_t;

	typedef struct {
		logic [pwms_pkg::DATA_BITS-1:0] rd;
		logic [pwms_pkg::REPORT_CH-1:0] level;
		logic [pwms_pkg::REPORT_CH-1:0] started;
	} pwm_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [pwms_pkg::FUNC_BITS-1:0] func = '0;
	logic [pwms_pkg::CH_BITS-1:0] channel = '0;
	logic [pwms_pkg::SEL_BITS-1:0] reg_sel = '0;
	logic [pwms_pkg::DATA_BITS-1:0] write_data = '0;
	logic result_valid;
	logic result_stall = 1'b1;
	logic [pwms_pkg::DATA_BITS-1:0] read_data;
	logic [pwms_pkg::REPORT_CH-1:0] pwm_level;
	logic [pwms_pkg::REPORT_CH-1:0] started_mask;

	pwm_op_t op_queue[$];
	pwm_view_t view_queue[$];
	int total_items = 0;
	int accepted_items = 0;
	int mismatches = 0;
	bit offer_taken = 1'b0;
	bit holdoff_done = 1'b0;
	int holdoff_left = 0;

	// Model state of each channel
	logic [pwms_pkg::CTL_BITS-1:0] ctl_word[CH_N];
	logic [31:0] sh_period[CH_N];
	logic [31:0] sh_duty[CH_N];
	logic [31:0] act_period[CH_N];
	logic [31:0] act_duty[CH_N];
	logic [31:0] count[CH_N];
	bit pend_update[CH_N];
	bit running[CH_N];

	multichannel_pwm_with_shadow_update dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.channel      (channel),
		.reg_sel      (reg_sel),
		.write_data   (write_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.pwm_level    (pwm_level),
		.started_mask (started_mask)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("testbench: errors");
		$finish;
	end

	// Shadows become active at a period start when an update is armed
	function automatic void load_shadows(input int ch);
		if (pend_update[ch]) begin
			act_period[ch] = sh_period[ch];
			act_duty[ch] = sh_duty[ch];
			pend_update[ch] = 1'b0;
		end
	endfunction

	// Advance the model by one operation and return what the block reports
	function automatic pwm_view_t apply_operation(input pwm_op_t op);
		pwm_view_t v;
		logic [pwms_pkg::CTL_BITS-1:0] nw;
		logic [pwms_pkg::CTL_BITS-1:0] old;
		bit first_lvl;
		int ch;
		v.rd = '0;
		v.level = '0;
		v.started = '0;
		ch = op.chan;
		if (op.func == pwms_pkg::FUNC_TICK) begin
			for (int c = 0; c < CH_N; c++) begin
				if (running[c]) begin
					if ({1'b0, count[c]} + 33'd1 >= {1'b0, act_period[c]}) begin
						count[c] = '0;
						load_shadows(c);
					end else begin
						count[c] = (count[c] + 32'd1) & COUNT_MASK;
					end
				end
			end
		end else if (op.func == pwms_pkg::FUNC_WRITE && ch < CH_N) begin
			case (op.sel)
				pwms_pkg::SEL_CTL: begin
					old = ctl_word[ch];
					nw = op.data[pwms_pkg::CTL_BITS-1:0];
					// first-phase level is frozen once started
					if (running[ch])
						nw[pwms_pkg::CTL_LVL_BIT] = old[pwms_pkg::CTL_LVL_BIT];
					if (!old[pwms_pkg::CTL_UPD_BIT] && nw[pwms_pkg::CTL_UPD_BIT])
						pend_update[ch] = 1'b1;
					if (nw[pwms_pkg::CTL_START_BIT] && !running[ch]) begin
						running[ch] = 1'b1;
						count[ch] = '0;
						load_shadows(ch);
					end
					nw[pwms_pkg::CTL_START_BIT] = 1'b0;
					ctl_word[ch] = nw;
				end
				pwms_pkg::SEL_PERIOD: sh_period[ch] = op.data & COUNT_MASK;
				pwms_pkg::SEL_DUTY: sh_duty[ch] = op.data & COUNT_MASK;
				default: ;
			endcase
		end else if (op.func == pwms_pkg::FUNC_READ && ch < CH_N) begin
			case (op.sel)
				pwms_pkg::SEL_CTL: v.rd = 32'(ctl_word[ch]);
				pwms_pkg::SEL_PERIOD: v.rd = sh_period[ch];
				pwms_pkg::SEL_DUTY: v.rd = sh_duty[ch];
				default: v.rd = '0;
			endcase
		end
		for (int c = 0; c < CH_N && c < pwms_pkg::REPORT_CH; c++) begin
			if (running[c]) begin
				first_lvl = ctl_word[c][pwms_pkg::CTL_LVL_BIT];
				v.started[c] = 1'b1;
				v.level[c] = (count[c] < act_duty[c]) ? first_lvl : !first_lvl;
			end
		end
		return v;
	endfunction

	// Idle percentage of either side in the current phase
	function automatic int idle_percent(input bit sender);
		int phase;
		phase = (total_items == 0) ? 2 : (accepted_items * 3) / total_items;
		if (phase == 0)
			return sender ? 37 : 75;
		if (phase == 1)
			return sender ? 75 : 37;
		return 0;
	endfunction

	function automatic logic [31:0] count_value();
		if ($urandom_range(49) == 0)
			return $urandom;
		return 32'($urandom_range(0, 9));
	endfunction

	task automatic push_op(input logic [1:0] f, input logic [2:0] ch, input logic [1:0] sel,
			input logic [31:0] data);
		pwm_op_t op;
		op.func = f;
		op.chan = ch;
		op.sel = sel;
		op.data = data;
		op_queue.push_back(op);
	endtask

	// Stimulus: directed opening, then random programming sequences and noise
	initial begin : stimulus
		int target;
		int ch;
		logic [31:0] d;
		for (int c = 0; c < CH_N; c++) begin
			ctl_word[c] = '0;
			sh_period[c] = '0;
			sh_duty[c] = '0;
			act_period[c] = '0;
			act_duty[c] = '0;
			count[c] = '0;
			pend_update[c] = 1'b0;
			running[c] = 1'b0;
		end
		push_op(pwms_pkg::FUNC_READ, 3'd0, pwms_pkg::SEL_CTL, 32'd0);
		push_op(pwms_pkg::FUNC_WRITE, 3'd0, pwms_pkg::SEL_PERIOD, 32'd5);
		push_op(pwms_pkg::FUNC_WRITE, 3'd0, pwms_pkg::SEL_DUTY, 32'd2);
		push_op(pwms_pkg::FUNC_WRITE, 3'd0, pwms_pkg::SEL_CTL, 32'h104);
		// update bit already high: start alone, nothing newly armed
		push_op(pwms_pkg::FUNC_WRITE, 3'd0, pwms_pkg::SEL_CTL, 32'h105);
		repeat (6) push_op(pwms_pkg::FUNC_TICK, 3'd0, pwms_pkg::SEL_CTL, 32'd0);
		// level bit locked after start
		push_op(pwms_pkg::FUNC_WRITE, 3'd0, pwms_pkg::SEL_CTL, 32'hFFFF_FEFA);
		push_op(pwms_pkg::FUNC_READ, 3'd0, pwms_pkg::SEL_CTL, 32'd0);
		// duty above period
		push_op(pwms_pkg::FUNC_WRITE, 3'd1, pwms_pkg::SEL_DUTY, 32'hFFFF_FFFF);
		push_op(pwms_pkg::FUNC_WRITE, 3'd1, pwms_pkg::SEL_PERIOD, 32'd3);
		push_op(pwms_pkg::FUNC_WRITE, 3'd1, pwms_pkg::SEL_CTL, 32'h105);
		// zero duty, zero period
		push_op(pwms_pkg::FUNC_WRITE, 3'd2, pwms_pkg::SEL_CTL, 32'h101);
		// start on a running channel
		push_op(pwms_pkg::FUNC_WRITE, 3'd0, pwms_pkg::SEL_CTL, 32'h001);
		push_op(pwms_pkg::FUNC_WRITE, 3'd7, pwms_pkg::SEL_PERIOD, 32'hA5A5_5A5A);
		push_op(pwms_pkg::FUNC_WRITE, 3'd3, SEL_NONE, 32'hFFFF_FFFF);
		push_op(FUNC_NOP, 3'd5, pwms_pkg::SEL_DUTY, 32'h5555_AAAA);
		push_op(pwms_pkg::FUNC_READ, 3'd6, pwms_pkg::SEL_CTL, 32'd0);
		push_op(pwms_pkg::FUNC_READ, 3'd1, SEL_NONE, 32'd0);
		push_op(pwms_pkg::FUNC_READ, 3'd1, pwms_pkg::SEL_PERIOD, 32'd0);
		push_op(pwms_pkg::FUNC_TICK, 3'd7, SEL_NONE, 32'hFFFF_FFFF);

		target = op_queue.size() + TOTAL_RANDOM;
		while (op_queue.size() < target) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
					// program shadows, toggle update, maybe start, then run
					ch = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
						: $urandom_range(0, CH_N - 1);
					push_op(pwms_pkg::FUNC_WRITE, 3'(ch), pwms_pkg::SEL_PERIOD, count_value());
					push_op(pwms_pkg::FUNC_WRITE, 3'(ch), pwms_pkg::SEL_DUTY, count_value());
					d = $urandom;
					d[pwms_pkg::CTL_UPD_BIT] = 1'b0;
					d[pwms_pkg::CTL_START_BIT] = 1'b0;
					push_op(pwms_pkg::FUNC_WRITE, 3'(ch), pwms_pkg::SEL_CTL, d);
					d = $urandom;
					d[pwms_pkg::CTL_UPD_BIT] = 1'b1;
					d[pwms_pkg::CTL_START_BIT] = ($urandom_range(0, 1) == 1);
					push_op(pwms_pkg::FUNC_WRITE, 3'(ch), pwms_pkg::SEL_CTL, d);
					if ($urandom_range(0, 1) == 1)
						push_op(pwms_pkg::FUNC_READ, 3'(ch), 2'($urandom_range(0, 2)), $urandom);
					repeat ($urandom_range(1, 12))
						push_op(pwms_pkg::FUNC_TICK, 3'($urandom), 2'($urandom), $urandom);
				end
				10, 11, 12, 13, 14, 15: begin
					repeat ($urandom_range(1, 20))
						push_op(pwms_pkg::FUNC_TICK, 3'($urandom), 2'($urandom), $urandom);
				end
				16, 17, 18: begin
					repeat ($urandom_range(1, 4))
						push_op(pwms_pkg::FUNC_READ, 3'($urandom), 2'($urandom), $urandom);
				end
				default: begin
					push_op(2'($urandom), 3'($urandom), 2'($urandom), $urandom);
				end
			endcase
		end
		total_items = op_queue.size();
	end

	// Input driver: next transaction once the current one has gone in
	always @(negedge clk) begin : driver
		pwm_op_t op;
		if (arst_n && (!item_valid || offer_taken)) begin
			if (op_queue.size() > 0 && $urandom_range(0, 99) >= idle_percent(1'b1)) begin
				op = op_queue.pop_front();
				func <= op.func;
				channel <= op.chan;
				reg_sel <= op.sel;
				write_data <= op.data;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall, plus one long hold-off in the last phase
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (holdoff_left > 0) begin
				holdoff_left <= holdoff_left - 1;
				result_stall <= 1'b1;
			end else if (!holdoff_done && total_items > 0
					&& accepted_items * 3 >= total_items * 2) begin
				holdoff_done <= 1'b1;
				holdoff_left <= HOLDOFF_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < idle_percent(1'b0));
			end
		end
	end

	// Monitor: predict accepted transactions, check delivered results
	always @(posedge clk) begin : monitor
		pwm_op_t op;
		pwm_view_t want;
		if (arst_n) begin
			offer_taken = item_valid && !item_stall;
			if (offer_taken) begin
				op.func = func;
				op.chan = channel;
				op.sel = reg_sel;
				op.data = write_data;
				view_queue.push_back(apply_operation(op));
				accepted_items++;
			end
			if (result_valid && !result_stall) begin
				if (view_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected result: rd=%h lvl=%b st=%b",
							read_data, pwm_level, started_mask);
				end else begin
					want = view_queue.pop_front();
					if (read_data !== want.rd || pwm_level !== want.level
							|| started_mask !== want.started) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("mismatch: exp rd=%h lvl=%b st=%b, got rd=%h lvl=%b st=%b",
								want.rd, want.level, want.started,
								read_data, pwm_level, started_mask);
					end
				end
			end
		end
	end

	// End of run once everything has drained
	initial begin : finish_run
		wait (arst_n);
		@(posedge clk);
		while (total_items == 0 || op_queue.size() != 0 || item_valid
				|| view_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && view_queue.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

### files.f
hw/rtl/pwms_pkg.sv
hw/rtl/pwms_front.sv
hw/rtl/pwms_queue.sv
hw/rtl/pwms_back.sv
hw/rtl/multichannel_pwm_with_shadow_update.sv
bench/testbench.sv
